/* hdl/plid_pkg.sv */
package plid_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_UPDATE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_UPDATE = 2'd3
    } cell_op_t;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int FILL_W = 6;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos;
        logic signed [DATA_W-1:0] wdata;
    } cell_ctrl_t;

endpackage

/* hdl/plid_ifs.sv */
interface plid_in_if
    import plid_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, output cmd, output position, output data_in, input ready);
    modport sink   (input valid, input cmd, input position, input data_in, output ready);
endinterface

interface plid_out_if
    import plid_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
    logic [FILL_W-1:0]        fill_count;

    modport source (output valid, output data_out, output status, output fill_count, input ready);
    modport sink   (input valid, input data_out, input status, input fill_count, output ready);
endinterface

/* hdl/positional_list_insert_delete.sv */
// The result beat is registered and presented in the cycle after the command beat is accepted.
// Throughput: one command per cycle unless out_ch back-pressures; cells shift or write in parallel.
// Read-back is a select across the cell row at the addressed index.
// Reset (rst_n, async, active low) clears the entry count and the output valid;
// entry contents are not cleared and are never read before being written.
module positional_list_insert_delete
    import plid_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    plid_in_if.sink     in_ch,
    plid_out_if.source  out_ch
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    logic signed [DATA_W-1:0] dout_reg;
    logic signed [DATA_W-1:0] dout_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [FILL_W-1:0]        fill_reg;
    logic [FILL_W-1:0]        fill_next;

    logic signed [DATA_W-1:0] cell_val [CAPACITY];
    logic signed [DATA_W-1:0] rd_val;
    cell_ctrl_t               ctrl;
    logic                     accept;
    logic [XW-1:0]            pos_x;
    logic [XW-1:0]            count_x;
    logic [XW-1:0]            count_next_x;
    cmd_t                     cmd;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign cmd         = cmd_t'(in_ch.cmd);
    assign pos_x       = XW'(in_ch.position);
    assign count_x     = XW'(count_reg);

    always_comb
    begin
        rd_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (pos_x == XW'(i))
            begin
                rd_val = cell_val[i];
            end
        end
    end

    always_comb
    begin
        ctrl.op     = OP_HOLD;
        ctrl.pos    = in_ch.position;
        ctrl.wdata  = in_ch.data_in;
        count_next  = count_reg;
        dout_next   = '0;
        status_next = ST_OK;
        if (cmd == CMD_INSERT)
        begin
            if (count_x >= XW'(CAPACITY))
            begin
                status_next = ST_FULL;
            end
            else if (pos_x > count_x)
            begin
                status_next = ST_RANGE;
            end
            else
            begin
                ctrl.op    = OP_INSERT;
                count_next = count_reg + CW'(1);
            end
        end
        else if (pos_x >= count_x)
        begin
            status_next = ST_RANGE;
        end
        else
        begin
            case (cmd)
                CMD_DELETE:
                begin
                    ctrl.op    = OP_DELETE;
                    dout_next  = rd_val;
                    count_next = count_reg - CW'(1);
                end
                CMD_UPDATE:
                begin
                    ctrl.op   = OP_UPDATE;
                    dout_next = in_ch.data_in;
                end
                default:
                begin
                    dout_next = rd_val;
                end
            endcase
        end
        if (!accept)
        begin
            ctrl.op    = OP_HOLD;
            count_next = count_reg;
        end
    end

    assign count_next_x = XW'(count_next);
    assign fill_next    = count_next_x[FILL_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_val;
            logic signed [DATA_W-1:0] right_val;
            if (g == 0)
            begin : g_first
                assign left_val = in_ch.data_in;
            end
            else
            begin : g_mid_l
                assign left_val = cell_val[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_val = '0;
            end
            else
            begin : g_mid_r
                assign right_val = cell_val[g+1];
            end
            plid_cell #(
                .IDX (g)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .left_val  (left_val),
                .right_val (right_val),
                .value     (cell_val[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dout_reg   <= dout_next;
            status_reg <= status_next;
            fill_reg   <= fill_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.data_out   = dout_reg;
    assign out_ch.status     = status_reg;
    assign out_ch.fill_count = fill_reg;

endmodule

/* hdl/plid_cell.sv */
module plid_cell
    import plid_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] left_val,
    input  logic signed [DATA_W-1:0] right_val,
    output logic signed [DATA_W-1:0] value
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (IDX > int'(ctrl.pos))
                begin
                    value_next = left_val;
                end
                else if (IDX == int'(ctrl.pos))
                begin
                    value_next = ctrl.wdata;
                end
            end
            OP_DELETE:
            begin
                if (IDX >= int'(ctrl.pos))
                begin
                    value_next = right_val;
                end
            end
            OP_UPDATE:
            begin
                if (IDX == int'(ctrl.pos))
                begin
                    value_next = ctrl.wdata;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* bench/plid_sb_pkg.sv */
package plid_sb_pkg;
    import plid_pkg::*;

    localparam int LIST_DEPTH = 32;

    typedef struct {
        logic signed [DATA_W-1:0] data_out;
        status_t                  status;
        logic [FILL_W-1:0]        fill;
    } list_result_t;

    class list_scoreboard;
        logic signed [DATA_W-1:0] shadow_cells [LIST_DEPTH];
        int                       shadow_count = 0;
        list_result_t             pending_results [$];
        int                       errors = 0;
        int                       n_in = 0;
        int                       n_checked = 0;
        int                       full_hits = 0;
        int                       n_by_cmd [4];
        int                       n_by_status [3];

        function int pending_count();
            return pending_results.size();
        endfunction

        task report(input string msg);
            if (errors < 40)
            begin
                $display("MISMATCH: %s", msg);
            end
            errors++;
        endtask

        // List update for one accepted command beat; queues the result it must produce.
        function void note_command(cmd_t op, logic [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] din);
            list_result_t r;
            int           i;
            r.data_out = '0;
            r.status   = ST_OK;
            n_in++;
            n_by_cmd[op]++;
            if (op == CMD_INSERT)
            begin
                if (shadow_count >= LIST_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else if (pos > shadow_count)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    for (i = shadow_count; i > pos; i--)
                    begin
                        shadow_cells[i] = shadow_cells[i-1];
                    end
                    shadow_cells[pos] = din;
                    shadow_count++;
                    if (shadow_count == LIST_DEPTH)
                    begin
                        full_hits++;
                    end
                end
            end
            else if (pos >= shadow_count)
            begin
                r.status = ST_RANGE;
            end
            else if (op == CMD_DELETE)
            begin
                r.data_out = shadow_cells[pos];
                for (i = pos; i + 1 < shadow_count; i++)
                begin
                    shadow_cells[i] = shadow_cells[i+1];
                end
                shadow_count--;
            end
            else if (op == CMD_READ)
            begin
                r.data_out = shadow_cells[pos];
            end
            else
            begin
                shadow_cells[pos] = din;
                r.data_out = din;
            end
            r.fill = shadow_count[FILL_W-1:0];
            n_by_status[r.status]++;
            pending_results.push_back(r);
        endfunction

        task check_result(input logic signed [DATA_W-1:0] dout, input logic [1:0] st,
                          input logic [FILL_W-1:0] fill);
            list_result_t r;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result beat with nothing pending: data %0d status %0d fill %0d",
                                 dout, st, fill));
            end
            else
            begin
                r = pending_results.pop_front();
                n_checked++;
                if (dout !== r.data_out)
                begin
                    report($sformatf("result %0d data_out %0d, want %0d",
                                     n_checked, dout, r.data_out));
                end
                if (st !== r.status)
                begin
                    report($sformatf("result %0d status %0d, want %0d",
                                     n_checked, st, r.status));
                end
                if (fill !== r.fill)
                begin
                    report($sformatf("result %0d fill_count %0d, want %0d",
                                     n_checked, fill, r.fill));
                end
            end
        endtask
    endclass

endpackage

/* bench/tb_positional_list_insert_delete.sv */
module tb_positional_list_insert_delete;
    import plid_pkg::*;
    import plid_sb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 900;

    logic clk;
    logic rst_n;
    logic hold_off;
    int   cycles = 0;

    plid_in_if  cmd_ch ();
    plid_out_if res_ch ();

    list_scoreboard sb = new();

    positional_list_insert_delete #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, sb.pending_count());
        $display("tb_positional_list_insert_delete: errors");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 60);
    endfunction

    // result side: random back-pressure, quiet stretches, and one long hold-off
    initial
    begin
        int  stall_left;
        int  mode_left;
        bit  quiet;
        stall_left = 0;
        mode_left = 0;
        quiet = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                sb.check_result(res_ch.data_out, res_ch.status, res_ch.fill_count);
            end
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(50, 300);
                quiet = ($urandom_range(0, 3) == 0);
            end
            mode_left--;
            if (hold_off)
            begin
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 25)
            begin
                stall_left = idle_len() - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        hold_off <= 1'b0;
        while (sb.n_in < 300)
        begin
            @(posedge clk);
        end
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic send_command(input cmd_t op, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] din, input bit quiet);
        int gap;
        gap = (quiet || $urandom_range(0, 99) >= 30) ? 0 : idle_len();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.cmd      <= op;
        cmd_ch.position <= pos;
        cmd_ch.data_in  <= din;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_command(op, pos, din);
    endtask

    task automatic run_directed();
        send_command(CMD_READ,   6'd0,  32'sd0, 1'b0);
        send_command(CMD_DELETE, 6'd0,  32'sd0, 1'b0);
        send_command(CMD_UPDATE, 6'd0,  32'sd77, 1'b0);
        send_command(CMD_INSERT, 6'd1,  32'sd5, 1'b0);
        send_command(CMD_INSERT, 6'd63, 32'sd5, 1'b0);
        send_command(CMD_INSERT, 6'd0,  32'sh7FFF_FFFF, 1'b0);
        send_command(CMD_INSERT, 6'd0,  32'sh8000_0000, 1'b0);
        send_command(CMD_INSERT, 6'd2,  -32'sd1, 1'b0);
        send_command(CMD_INSERT, 6'd1,  32'sh1234_5678, 1'b0);
        send_command(CMD_READ,   6'd3,  32'sh0F0F_0F0F, 1'b0);
        send_command(CMD_READ,   6'd4,  32'sd0, 1'b0);
        send_command(CMD_UPDATE, 6'd2,  32'sh5A5A_5A5A, 1'b0);
        send_command(CMD_UPDATE, 6'd63, 32'sh5A5A_5A5A, 1'b0);
        send_command(CMD_DELETE, 6'd1,  32'sd0, 1'b0);
        send_command(CMD_READ,   6'd1,  32'sd0, 1'b0);
        send_command(CMD_DELETE, 6'd2,  32'sd0, 1'b0);
        send_command(CMD_DELETE, 6'd0,  32'sd0, 1'b0);
        send_command(CMD_READ,   6'd0,  32'sd0, 1'b0);
        send_command(CMD_DELETE, 6'd0,  32'sd0, 1'b0);
        send_command(CMD_DELETE, 6'd0,  32'sd0, 1'b0);
        send_command(CMD_INSERT, 6'd0,  32'sd0, 1'b0);
        send_command(CMD_READ,   6'd32, 32'sd0, 1'b0);
        send_command(CMD_DELETE, 6'd63, 32'sd0, 1'b0);
    endtask

    // segments that bias toward growing, shrinking or mixed traffic
    task automatic run_random(input int total);
        int                       sent;
        int                       seg_left;
        int                       mode;
        int                       r;
        int                       used;
        bit                       quiet;
        cmd_t                     op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] din;
        sent = 0;
        seg_left = 0;
        mode = 0;
        quiet = 1'b0;
        while (sent < total)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 60);
                mode = $urandom_range(0, 2);
                quiet = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (mode == 0)
            begin
                if (r < 75)      op = CMD_INSERT;
                else if (r < 85) op = CMD_DELETE;
                else if (r < 93) op = CMD_READ;
                else             op = CMD_UPDATE;
            end
            else if (mode == 1)
            begin
                if (r < 70)      op = CMD_DELETE;
                else if (r < 80) op = CMD_INSERT;
                else if (r < 90) op = CMD_READ;
                else             op = CMD_UPDATE;
            end
            else
            begin
                if (r < 25)      op = CMD_INSERT;
                else if (r < 50) op = CMD_DELETE;
                else if (r < 75) op = CMD_READ;
                else             op = CMD_UPDATE;
            end
            used = sb.shadow_count;
            if ($urandom_range(0, 9) == 0)
            begin
                pos = POS_W'($urandom_range(0, 63));
            end
            else if (op == CMD_INSERT)
            begin
                pos = POS_W'($urandom_range(0, used));
            end
            else
            begin
                pos = (used == 0) ? '0 : POS_W'($urandom_range(0, used - 1));
            end
            din = $urandom;
            if ($urandom_range(0, 15) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: din = 32'sh7FFF_FFFF;
                    1: din = 32'sh8000_0000;
                    2: din = 32'sd0;
                    default: din = -32'sd1;
                endcase
            end
            send_command(op, pos, din, quiet);
            sent++;
            seg_left--;
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.cmd      <= CMD_READ;
        cmd_ch.position <= '0;
        cmd_ch.data_in  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RANDOM_ITEMS);
        cmd_ch.valid <= 1'b0;
        while (sb.pending_count() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        $display("%0d commands: %0d insert, %0d delete, %0d read, %0d update; %0d results checked",
                 sb.n_in, sb.n_by_cmd[CMD_INSERT], sb.n_by_cmd[CMD_DELETE],
                 sb.n_by_cmd[CMD_READ], sb.n_by_cmd[CMD_UPDATE], sb.n_checked);
        $display("status ok %0d, out of range %0d, refused on full %0d; list filled %0d times",
                 sb.n_by_status[ST_OK], sb.n_by_status[ST_RANGE],
                 sb.n_by_status[ST_FULL], sb.full_hits);
        if (sb.errors == 0)
        begin
            $display("tb_positional_list_insert_delete: clean");
        end
        else
        begin
            $display("tb_positional_list_insert_delete: errors");
        end
        $finish;
    end

endmodule
